@@ rtl/cdp_pkg.sv @@
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared widths, command codes and reset values of the complex dot product.
// ----------------------------------------------------------------------------
package cdp_pkg;

    localparam int IDX_W   = 10;
    localparam int SMP_W   = 16;
    localparam int MUL_W   = 2 * SMP_W;
    localparam int PROD_W  = MUL_W + 1;
    localparam int ACC_W   = 48;
    localparam int CFG_W   = 11;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 2 * ACC_W;
    localparam int TAP_COUNT_RST = 1024;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

endpackage

@@ rtl/cdp_ram.sv @@
// ----------------------------------------------------------------------------
// cdp_ram
// Generic single-port RAM with registered read; read data holds when idle.
// ----------------------------------------------------------------------------
module cdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/complex_dot_product_top.sv @@
// ----------------------------------------------------------------------------
// complex_dot_product_top
// Complex multiply-accumulate dot product over a stored coefficient vector.
//
//   channel  dir  handshake              payload
//   s        in   i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser (cmd)
//   m        out  o_m_tvalid/i_m_tready  o_m_tdata (sum_real, sum_imag)
//   cfg      in   i_cfg_we               i_cfg_wdata (tap_count)
//
// One transfer per cycle unless stalled; the coefficient RAM port serves one
// load write or one sample read per cycle. Sums are registered behind the
// stage-one and product registers. Reset clears position and sums and sets
// tap_count to TAP_COUNT_RST; the RAM is not cleared. The input stalls only
// when a finished sum waits at the output and the pipeline behind is full.
// ----------------------------------------------------------------------------
module complex_dot_product_top
    import cdp_pkg::*;
#(
    parameter int MAX_TAPS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // coef_index, coef_real, coef_imag, sample_real, sample_imag, zero pad
    input  logic [IN_W-1:0]  i_s_tdata,
    // cmd
    input  logic             i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // sum_real, sum_imag
    output logic [OUT_W-1:0] o_m_tdata,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int POS_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int CMP_W = (POS_W + 1 > CNT_W) ? POS_W + 1 : CNT_W;
    localparam int RST_COUNT = (TAP_COUNT_RST > MAX_TAPS) ? MAX_TAPS : TAP_COUNT_RST;

    logic [IDX_W-1:0]        s_idx;
    logic signed [SMP_W-1:0] s_cr;
    logic signed [SMP_W-1:0] s_ci;
    logic signed [SMP_W-1:0] s_sr;
    logic signed [SMP_W-1:0] s_si;

    assign s_idx = i_s_tdata[9:0];
    assign s_cr  = i_s_tdata[25:10];
    assign s_ci  = i_s_tdata[41:26];
    assign s_sr  = i_s_tdata[57:42];
    assign s_si  = i_s_tdata[73:58];

    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    logic             r_v1;
    logic             r_l1;
    logic signed [SMP_W-1:0] r_a;
    logic signed [SMP_W-1:0] r_b;

    logic             r_v2;
    logic             r_l2;
    logic signed [PROD_W-1:0] r_pr;
    logic signed [PROD_W-1:0] r_pi;

    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic signed [ACC_W-1:0] n_acc_re;
    logic signed [ACC_W-1:0] n_acc_im;

    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_data;

    logic accept;
    logic is_sample;
    logic is_last;
    logic stall2;
    logic adv1;
    logic done2;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] pos_inc;
    logic [CMP_W-1:0] cnt_ext;
    logic [POS_W+IDX_W-1:0] idx_wide;
    logic             ld_ok;

    logic             ram_we;
    logic [POS_W-1:0] ram_addr;
    logic [MUL_W-1:0] ram_wdata;
    logic [MUL_W-1:0] ram_rdata;

    logic signed [SMP_W-1:0] c_re;
    logic signed [SMP_W-1:0] c_im;
    logic signed [MUL_W-1:0] p_ac;
    logic signed [MUL_W-1:0] p_bd;
    logic signed [MUL_W-1:0] p_ad;
    logic signed [MUL_W-1:0] p_bc;

    logic [31:0] cfg_val;
    logic [CNT_W-1:0] n_count;

    assign stall2     = r_v2 && r_l2 && r_out_vld && !i_m_tready;
    assign adv1       = !r_v2 || !stall2;
    assign o_s_tready = !r_v1 || adv1;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_sample  = (t_cmd'(i_s_tuser) == CMD_SAMPLE);
    assign done2      = r_v2 && !stall2;

    assign pos_ext = CMP_W'(r_pos);
    assign pos_inc = pos_ext + CMP_W'(1);
    assign cnt_ext = CMP_W'(r_count);
    assign is_last = (pos_inc >= cnt_ext);

    always_comb begin
        n_pos = r_pos;
        if (accept && is_sample) begin
            n_pos = is_last ? '0 : POS_W'(pos_inc);
        end
    end

    assign idx_wide  = {{POS_W{1'b0}}, s_idx};
    assign ld_ok     = (32'(s_idx) < MAX_TAPS);
    assign ram_we    = accept && !is_sample && ld_ok;
    assign ram_addr  = is_sample ? r_pos : idx_wide[POS_W-1:0];
    assign ram_wdata = {s_ci, s_cr};

    cdp_ram #(
        .WIDTH (MUL_W),
        .DEPTH (MAX_TAPS),
        .AW    (POS_W)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_en    (o_s_tready),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign c_re = ram_rdata[SMP_W-1:0];
    assign c_im = ram_rdata[MUL_W-1:SMP_W];
    assign p_ac = r_a * c_re;
    assign p_bd = r_b * c_im;
    assign p_ad = r_a * c_im;
    assign p_bc = r_b * c_re;

    assign n_acc_re = r_acc_re + ACC_W'(r_pr);
    assign n_acc_im = r_acc_im + ACC_W'(r_pi);

    assign cfg_val = 32'(i_cfg_wdata);
    always_comb begin
        if (cfg_val == 32'd0) begin
            n_count = CNT_W'(1);
        end else if (cfg_val > MAX_TAPS) begin
            n_count = CNT_W'(MAX_TAPS);
        end else begin
            n_count = CNT_W'(cfg_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CNT_W'(RST_COUNT);
            r_pos     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_acc_re  <= '0;
            r_acc_im  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= n_count;
            end
            r_pos <= n_pos;
            if (o_s_tready) begin
                r_v1 <= accept && is_sample;
            end
            if (adv1) begin
                r_v2 <= r_v1;
            end
            if (done2) begin
                if (r_l2) begin
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end else begin
                    r_acc_re <= n_acc_re;
                    r_acc_im <= n_acc_im;
                end
            end
            if (done2 && r_l2) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_l1 <= is_last;
            r_a  <= s_sr;
            r_b  <= s_si;
        end
        if (adv1) begin
            r_l2 <= r_l1;
            r_pr <= PROD_W'(p_ac) - PROD_W'(p_bd);
            r_pi <= PROD_W'(p_ad) + PROD_W'(p_bc);
        end
        if (done2 && r_l2) begin
            r_out_data <= {n_acc_im, n_acc_re};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_v2 && r_l2 && r_out_vld))
        else $error("input stalled with room in the pipeline");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done2 && r_l2) |=> (r_acc_re == '0 && r_acc_im == '0 && r_out_vld))
        else $error("sum not emitted or accumulators not cleared");

    a_stage1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !o_s_tready) |=> (r_v1 && $stable(r_a) && $stable(r_b)
            && $stable(ram_rdata)))
        else $error("stage one item lost while stalled");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (32'(r_count) <= MAX_TAPS))
        else $error("tap count out of range");

endmodule
